FILE: hw/rtl/csh_pkg.sv
package csh_pkg;

  // Default number of frames the stack holds.
  localparam int CSH_STACK_DEPTH = 64;

  // A frame keeps the upper 31 bits of the identifier and of the offset.
  localparam int PART_W  = 31;
  localparam int FRAME_W = 2 * PART_W;
  localparam int SRC_LSB = 33;

  localparam int MIX_SHIFT = 33;
  localparam logic [63:0] MIX_K1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_K2 = 64'hc4ceb9fe1a85ec53;

  localparam int DROP_W = 16;
  localparam logic [DROP_W-1:0] DROP_MAX = 16'hffff;

  localparam logic [1:0] FUNC_CALL = 2'd0;
  localparam logic [1:0] FUNC_RET  = 2'd1;
  localparam logic [1:0] FUNC_HASH = 2'd2;

  // Multiply sequencing: low x low, low x high, high x low.
  localparam logic [1:0] MSTEP_LL = 2'd0;
  localparam logic [1:0] MSTEP_LH = 2'd1;
  localparam logic [1:0] MSTEP_HL = 2'd2;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       hash_clr;
    logic       idx_inc;
    logic       rd;
    logic       xor_en;
    logic       part_sel;   // 0 identifier part, 1 offset part
    logic       mul_en;
    logic [1:0] mul_step;
    logic       k_sel;      // 0 first constant, 1 second constant
    logic       xs_en;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic walk_end;
    logic out_free;
  } status_t;

endpackage

FILE: hw/rtl/csh_ram.sv
module csh_ram #(
  parameter int WIDTH = csh_pkg::FRAME_W,
  parameter int DEPTH = csh_pkg::CSH_STACK_DEPTH,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/csh_ctrl.sv
module csh_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       func,
  input  csh_pkg::status_t status,
  output csh_pkg::cmd_t    cmd
);

  import csh_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CHK  = 3'd1;
  localparam logic [2:0] ST_XOR  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_XS   = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0] state, state_next;
  logic [1:0] step, step_next;
  logic       round, round_next;
  logic       part, part_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    step_next  = step;
    round_next = round;
    part_next  = part;
    cmd        = '0;
    cmd.part_sel = part;
    cmd.k_sel    = round;
    cmd.mul_step = step;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          // The hash register is cleared on every item, so it reads zero
          // as the signature of anything but a hash request.
          cmd.hash_clr = 1'b1;
          cmd.push     = (func == FUNC_CALL);
          cmd.pop      = (func == FUNC_RET);
          state_next   = (func == FUNC_HASH) ? ST_CHK : ST_DONE;
        end
      end
      ST_CHK: begin
        if (status.walk_end) begin
          state_next = ST_DONE;
        end else begin
          cmd.rd     = 1'b1;
          part_next  = 1'b0;
          state_next = ST_XOR;
        end
      end
      ST_XOR: begin
        cmd.xor_en = 1'b1;
        step_next  = MSTEP_LL;
        round_next = 1'b0;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        if (step == MSTEP_HL) begin
          step_next  = MSTEP_LL;
          state_next = ST_XS;
        end else begin
          step_next = step + 2'd1;
        end
      end
      ST_XS: begin
        cmd.xs_en = 1'b1;
        if (!round) begin
          round_next = 1'b1;
          state_next = ST_MUL;
        end else if (!part) begin
          part_next  = 1'b1;
          state_next = ST_XOR;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = ST_CHK;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= MSTEP_LL;
      round <= 1'b0;
      part  <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      round <= round_next;
      part  <= part_next;
    end
  end

endmodule

FILE: hw/rtl/csh_datapath.sv
module csh_datapath #(
  parameter int STACK_DEPTH = csh_pkg::CSH_STACK_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  csh_pkg::cmd_t    cmd,
  output csh_pkg::status_t status,
  input  logic [63:0]      image_id,
  input  logic [63:0]      return_offset,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [63:0]      signature,
  output logic [6:0]       depth,
  output logic             truncated
);

  import csh_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  logic [CW-1:0]     count;
  logic [CW-1:0]     idx;
  logic [DROP_W-1:0] dropped;
  logic [63:0]       hash;
  logic [63:0]       acc;

  logic              wr_en;
  logic [FRAME_W-1:0] wr_frame;
  logic [FRAME_W-1:0] rd_frame;
  logic [PART_W-1:0]  part_val;
  logic [63:0]        kval;
  logic [31:0]        op_a;
  logic [31:0]        op_b;
  logic [63:0]        prod;

  assign wr_en    = cmd.push && (count != FULL);
  assign wr_frame = {image_id[63:SRC_LSB], return_offset[63:SRC_LSB]};

  csh_ram #(
    .WIDTH(FRAME_W),
    .DEPTH(STACK_DEPTH),
    .AW   (AW)
  ) u_frames (
    .clk  (clk),
    .we   (wr_en),
    .waddr(count[AW-1:0]),
    .wdata(wr_frame),
    .re   (cmd.rd),
    .raddr(idx[AW-1:0]),
    .rdata(rd_frame)
  );

  assign part_val = cmd.part_sel ? rd_frame[PART_W-1:0] : rd_frame[FRAME_W-1:PART_W];

  // One 32x32 multiplier builds the low 64 bits of a 64x64 product in three passes.
  assign kval = cmd.k_sel ? MIX_K2 : MIX_K1;
  assign op_a = (cmd.mul_step == MSTEP_HL) ? hash[63:32] : hash[31:0];
  assign op_b = (cmd.mul_step == MSTEP_LH) ? kval[63:32] : kval[31:0];
  assign prod = 64'(op_a) * 64'(op_b);

  assign status.walk_end = (idx == count);
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= '0;
      idx     <= '0;
    end else begin
      if (cmd.push) begin
        if (count != FULL) begin
          count <= count + CW'(1);
        end else if (dropped != DROP_MAX) begin
          dropped <= dropped + DROP_W'(1);
        end
      end else if (cmd.pop) begin
        if (dropped != '0) begin
          dropped <= dropped - DROP_W'(1);
        end else if (count != '0) begin
          count <= count - CW'(1);
        end
      end
      if (cmd.hash_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hash_clr) begin
      hash <= '0;
    end else if (cmd.xor_en) begin
      hash <= hash ^ {{(64 - PART_W){1'b0}}, part_val};
    end else if (cmd.xs_en) begin
      hash <= acc ^ (acc >> MIX_SHIFT);
    end
    if (cmd.mul_en) begin
      if (cmd.mul_step == MSTEP_LL) begin
        acc <= prod;
      end else begin
        acc <= acc + {prod[31:0], 32'h0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      signature <= hash;
      depth     <= 7'(count);
      truncated <= (dropped != '0);
    end
  end

endmodule

FILE: hw/rtl/call_stack_signature_hasher_top.sv
// Call stack signature hasher.
// Input channel (in_valid, in_stall, func, image_id, return_offset): a call pushes a
// frame of the upper 31 bits of image_id and of return_offset, a return pops one and a
// hash request walks the stack from bottom to top through a 64-bit fmix-style mix.
// Output channel (out_valid, out_stall, signature, depth, truncated): exactly one
// result per input transfer, in order; signature is zero for anything but a hash.
// One item is processed at a time. A call, a return or an unused code goes straight to
// the done state, which loads its result into the output register. A hash request
// walks each frame through the check, xor, multiply and xor-shift states; the work per
// frame is set by the single 32x32 multiplier, which needs three passes per 64-bit
// product and two products for each half of a frame.
// A result that is stalled stays in the output register; the block still takes one
// more item, works it through and then holds it, with in_stall high, until the stalled
// result has been taken. The input is free again in the cycle after a result is loaded.
// Synchronous reset empties the stack and clears the dropped-push count and the
// output valid; stack memory contents are not cleared, as only written frames are read.
// Pushes on a full stack are counted and cancelled first by later pops; truncated
// reports that such pushes are outstanding.
module call_stack_signature_hasher_top #(
  parameter int STACK_DEPTH = csh_pkg::CSH_STACK_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [63:0] image_id,
  input  logic [63:0] return_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] signature,
  output logic [6:0]  depth,
  output logic        truncated
);

  import csh_pkg::*;

  cmd_t    cmd;
  status_t status;

  // The controller sequences the stack walk and the multiply passes.
  csh_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func    (func),
    .status  (status),
    .cmd     (cmd)
  );

  // The datapath holds the stack, the counters, the hash and the output register.
  csh_datapath #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .image_id     (image_id),
    .return_offset(return_offset),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .signature    (signature),
    .depth        (depth),
    .truncated    (truncated)
  );

endmodule
